// File: src/lsr_pkg.sv
// Package for the lagged subtractive random number generator.
// Holds widths, Park-Miller constants and the controller/datapath interface structs.
// No dependencies.
`default_nettype none

package lsr_pkg;

    localparam int VAL_W          = 31;
    localparam int MULT_W         = 16;
    localparam int PROD_W         = VAL_W + MULT_W;
    localparam int TABLE_LEN_DEF  = 55;
    localparam int TAP_OFFSET_DEF = 31;

    localparam logic [MULT_W-1:0] PM_MULT    = 16'd48271;
    localparam logic [VAL_W-1:0]  PM_MOD     = 31'h7FFF_FFFF;
    localparam logic [VAL_W-1:0]  SEED_RESET = 31'd1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic fill_start;   // write entry 0, load seed, rewind indexes
        logic fill_mul;     // multiply fill value by the Park-Miller multiplier
        logic fill_wr;      // reduce product, write next table entry
        logic draw_rd;      // read both tapped entries
        logic draw_wr;      // write difference back, load output, advance tap
    } lsr_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic fill_last;    // the entry being filled is the last one
        logic out_busy;     // output register holds a request not taken this cycle
    } lsr_status_t;

endpackage

`default_nettype wire

// File: src/lsr_ctrl.sv
// Controller state machine of the lagged subtractive generator.
// Depends on lsr_pkg for the command and status structs.
`default_nettype none

module lsr_ctrl
    import lsr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        restart,
    output logic             in_ready,
    input  wire lsr_status_t status,
    output lsr_cmd_t         cmd
);

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_FILL_ZERO = 3'd1;
    localparam logic [2:0] ST_FILL_MUL  = 3'd2;
    localparam logic [2:0] ST_FILL_WR   = 3'd3;
    localparam logic [2:0] ST_DRAW_RD   = 3'd4;
    localparam logic [2:0] ST_DRAW_WR   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       needs_seed_reg;
    logic       needs_seed_next;

    always_comb
    begin
        state_next      = state_reg;
        needs_seed_next = needs_seed_reg;
        cmd             = '0;
        in_ready        = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready     = 1'b1;
                // prefetch the tapped entries while waiting
                cmd.draw_rd  = 1'b1;
                if (in_valid)
                begin
                    if (restart || needs_seed_reg)
                        state_next = ST_FILL_ZERO;
                    else
                        state_next = ST_DRAW_WR;
                end
            end
            ST_FILL_ZERO:
            begin
                cmd.fill_start = 1'b1;
                state_next     = ST_FILL_MUL;
            end
            ST_FILL_MUL:
            begin
                cmd.fill_mul = 1'b1;
                state_next   = ST_FILL_WR;
            end
            ST_FILL_WR:
            begin
                cmd.fill_wr = 1'b1;
                if (status.fill_last)
                begin
                    needs_seed_next = 1'b0;
                    state_next      = ST_DRAW_RD;
                end
                else
                begin
                    state_next = ST_FILL_MUL;
                end
            end
            ST_DRAW_RD:
            begin
                cmd.draw_rd = 1'b1;
                state_next  = ST_DRAW_WR;
            end
            ST_DRAW_WR:
            begin
                // hold until the output register can take the request
                if (!status.out_busy)
                begin
                    cmd.draw_wr = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            needs_seed_reg <= 1'b1;
        end
        else
        begin
            state_reg      <= state_next;
            needs_seed_reg <= needs_seed_next;
        end
    end

endmodule

`default_nettype wire

// File: src/lsr_datapath.sv
// Datapath of the lagged subtractive generator: lag table memory, tap and fill
// indexes, Park-Miller multiply and Mersenne reduction, subtractor, output register.
// Depends on lsr_pkg.
`default_nettype none

module lsr_datapath
    import lsr_pkg::*;
#(
    parameter int TABLE_LEN  = TABLE_LEN_DEF,
    parameter int TAP_OFFSET = TAP_OFFSET_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             seed_wr,
    input  wire logic [VAL_W-1:0] seed,
    input  wire lsr_cmd_t         cmd,
    output lsr_status_t           status,
    input  wire logic             out_ready,
    output logic                  out_valid,
    output logic [VAL_W-1:0]      random_value
);

    localparam int IDX_W = $clog2(TABLE_LEN);
    localparam int OFF_M = TAP_OFFSET % TABLE_LEN;

    logic [VAL_W-1:0]  mem [TABLE_LEN];

    logic [VAL_W-1:0]  seed_reg;
    logic [IDX_W-1:0]  tap_idx_reg;
    logic [IDX_W-1:0]  tap_idx_next;
    logic [IDX_W-1:0]  fill_idx_reg;
    logic [IDX_W-1:0]  fill_idx_next;
    logic [VAL_W-1:0]  fill_value_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [VAL_W-1:0]  rd_cur_reg;
    logic [VAL_W-1:0]  rd_far_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [VAL_W-1:0]  out_data_reg;

    logic [IDX_W:0]    far_sum;
    logic [IDX_W-1:0]  far_idx;
    logic [VAL_W:0]    fold_sum;
    logic [VAL_W-1:0]  fold_res;
    logic [VAL_W-1:0]  diff;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_wa;
    logic [VAL_W-1:0]  mem_wd;

    // far tap: one compare and subtract, since cur + OFF_M < 2 * TABLE_LEN
    always_comb
    begin
        far_sum = {1'b0, tap_idx_reg} + (IDX_W+1)'(OFF_M);
        if (far_sum >= (IDX_W+1)'(TABLE_LEN))
            far_sum = far_sum - (IDX_W+1)'(TABLE_LEN);
        far_idx = far_sum[IDX_W-1:0];
    end

    // reduce mod 2^31-1: fold the high part onto the low part, then one subtract
    always_comb
    begin
        fold_sum = {1'b0, prod_reg[VAL_W-1:0]} + (VAL_W+1)'(prod_reg[PROD_W-1:VAL_W]);
        if (fold_sum >= {1'b0, PM_MOD})
            fold_res = VAL_W'(fold_sum - {1'b0, PM_MOD});
        else
            fold_res = fold_sum[VAL_W-1:0];
    end

    assign diff = rd_far_reg - rd_cur_reg;

    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = tap_idx_reg;
        mem_wd = diff;
        if (cmd.fill_start)
        begin
            mem_we = 1'b1;
            mem_wa = '0;
            mem_wd = '0;
        end
        else if (cmd.fill_wr)
        begin
            mem_we = 1'b1;
            mem_wa = fill_idx_reg;
            mem_wd = fold_res;
        end
        else if (cmd.draw_wr)
        begin
            mem_we = 1'b1;
        end
    end

    always_comb
    begin
        tap_idx_next  = tap_idx_reg;
        fill_idx_next = fill_idx_reg;
        if (cmd.fill_start)
        begin
            tap_idx_next  = '0;
            fill_idx_next = IDX_W'(1);
        end
        else if (cmd.fill_wr)
        begin
            fill_idx_next = fill_idx_reg + IDX_W'(1);
        end
        else if (cmd.draw_wr)
        begin
            if (tap_idx_reg == IDX_W'(TABLE_LEN - 1))
                tap_idx_next = '0;
            else
                tap_idx_next = tap_idx_reg + IDX_W'(1);
        end
    end

    always_comb
    begin
        if (cmd.draw_wr)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg      <= SEED_RESET;
            tap_idx_reg   <= '0;
            fill_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (seed_wr)
                seed_reg <= seed;
            tap_idx_reg   <= tap_idx_next;
            fill_idx_reg  <= fill_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fill_start)
            fill_value_reg <= seed_reg;
        else if (cmd.fill_wr)
            fill_value_reg <= fold_res;
        if (cmd.fill_mul)
            prod_reg <= PROD_W'(fill_value_reg) * PROD_W'(PM_MULT);
        if (cmd.draw_wr)
            out_data_reg <= diff;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        if (cmd.draw_rd)
        begin
            rd_cur_reg <= mem[tap_idx_reg];
            rd_far_reg <= mem[far_idx];
        end
    end

    assign status.fill_last = (fill_idx_reg == IDX_W'(TABLE_LEN - 1));
    assign status.out_busy  = out_valid_reg && !out_ready;
    assign out_valid        = out_valid_reg;
    assign random_value     = out_data_reg;

endmodule

`default_nettype wire

// File: src/lagged_subtractive_rng.sv
// Top level of the lagged subtractive random number generator.
// Instantiates lsr_ctrl and lsr_datapath; depends on lsr_pkg.
//
// Usage:
//   Input channel (in_valid / in_ready / restart): each request yields exactly
//   one random_value on the output channel (out_valid / out_ready). A set
//   restart bit rebuilds the lag table from the seed before the draw; the
//   first request after reset always rebuilds.
//   Seed channel (seed_valid / seed_ready / seed): writes the 31-bit seed
//   register; seed_ready is always high. A new seed takes effect at the next
//   rebuild. Write it only while the block is idle.
// Timing:
//   A plain draw uses the tapped entries prefetched from the table while idle;
//   the draw state then subtracts, writes back and loads the output register,
//   which raises out_valid. A new request is accepted only once the previous
//   draw has written back and the controller is idle again.
//   A rebuild first clears entry 0, then runs a multiply and a reduce step per
//   remaining entry through the single Park-Miller unit, then one table read
//   before the draw.
// Reset: rst_n is asynchronous, active low; the seed returns to 1 and the
//   table is marked as needing a rebuild.
// Stall: the result waits in the output register; the next request is still
//   accepted, and its draw holds before write-back until the output is taken.
`default_nettype none

module lagged_subtractive_rng
    import lsr_pkg::*;
#(
    parameter int TABLE_LEN  = TABLE_LEN_DEF,
    parameter int TAP_OFFSET = TAP_OFFSET_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             seed_valid,
    output logic                  seed_ready,
    input  wire logic [VAL_W-1:0] seed,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic             restart,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [VAL_W-1:0]      random_value
);

    lsr_cmd_t    cmd;
    lsr_status_t status;

    // the seed register is always free to take a write
    assign seed_ready = 1'b1;

    lsr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .restart  (restart),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    lsr_datapath #(
        .TABLE_LEN  (TABLE_LEN),
        .TAP_OFFSET (TAP_OFFSET)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .seed_wr      (seed_valid),
        .seed         (seed),
        .cmd          (cmd),
        .status       (status),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .random_value (random_value)
    );

endmodule

`default_nettype wire

// File: src/lsr_checker.sv
// Port-level checker for the lagged subtractive generator, bound to the top level.
// Depends on lsr_pkg for the value width.
`default_nettype none

module lsr_checker
    import lsr_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             in_valid,
    input wire logic             in_ready,
    input wire logic             out_valid,
    input wire logic             out_ready,
    input wire logic [VAL_W-1:0] random_value
);

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(random_value))
        else $error("output request changed while stalled");

    // an accepted request leaves the block busy, with in_ready low, in the cycle after
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("block ready right after accepting a request");

    // a new result appears only from a draw in progress
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared while block was idle");

endmodule

bind lagged_subtractive_rng lsr_checker u_lsr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .random_value (random_value)
);

`default_nettype wire

// File: verif/lsr_draw_check.sv
// Checker for the lagged subtractive random number generator: watches the seed,
// request and result channels, predicts each random_value and compares in order.
// Depends on lsr_pkg for widths and the Park-Miller constants.
module lsr_draw_check
    import lsr_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             seed_valid,
    input  wire logic             seed_ready,
    input  wire logic [VAL_W-1:0] seed,
    input  wire logic             in_valid,
    input  wire logic             in_ready,
    input  wire logic             restart,
    input  wire logic             out_valid,
    input  wire logic             out_ready,
    input  wire logic [VAL_W-1:0] random_value,
    output int                    mismatches,
    output int                    requests_taken,
    output int                    results_taken
);

    localparam int LAGS = TABLE_LEN_DEF;
    localparam int TAP  = TAP_OFFSET_DEF;

    logic [VAL_W-1:0] seed_now;
    logic [VAL_W-1:0] lags [LAGS];
    int unsigned      tap_pos;
    bit               table_stale;
    logic [VAL_W-1:0] draws_due [$];
    logic [VAL_W-1:0] want;
    int               error_total = 0;

    assign mismatches = error_total;

    task automatic report(input string msg);
        error_total++;
        $display("lsr check @%0t: %s", $time, msg);
    endtask

    function automatic logic [VAL_W-1:0] park_miller_next(input logic [VAL_W-1:0] x);
        logic [63:0] prod;
        prod = 64'(x) * 64'(PM_MULT);
        return VAL_W'(prod % 64'(PM_MOD));
    endfunction

    // Rebuild when asked or when the table was never filled, then take one draw.
    function automatic logic [VAL_W-1:0] draw_next(input logic rebuild);
        logic [VAL_W-1:0] fill;
        logic [VAL_W-1:0] diff;
        int unsigned      far_pos;
        if (rebuild || table_stale)
        begin
            fill    = seed_now;
            lags[0] = '0;
            for (int k = 1; k < LAGS; k++)
            begin
                fill    = park_miller_next(fill);
                lags[k] = fill;
            end
            tap_pos     = 0;
            table_stale = 1'b0;
        end
        far_pos       = (tap_pos + TAP) % LAGS;
        diff          = lags[far_pos] - lags[tap_pos];
        lags[tap_pos] = diff;
        tap_pos       = (tap_pos + 1) % LAGS;
        return diff;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_now    = SEED_RESET;
            table_stale = 1'b1;
            tap_pos     = 0;
            foreach (lags[i])
                lags[i] = '0;
            draws_due.delete();
            requests_taken <= 0;
            results_taken  <= 0;
        end
        else
        begin
            if (seed_valid && seed_ready)
                seed_now = seed;
            if (in_valid && in_ready)
            begin
                draws_due.push_back(draw_next(restart));
                requests_taken <= requests_taken + 1;
            end
            if (out_valid && out_ready)
            begin
                if (draws_due.size() == 0)
                    report($sformatf("random_value %0d with no request pending",
                                     random_value));
                else
                begin
                    want = draws_due.pop_front();
                    if (random_value !== want)
                        report($sformatf("random_value got %0d expected %0d",
                                         random_value, want));
                end
                results_taken <= results_taken + 1;
            end
        end
    end

endmodule

// File: verif/tb_top.sv
// Testbench top for lagged_subtractive_rng: drives seed writes and requests,
// idles both sides at random and gives the verdict. Depends on lsr_pkg and
// lsr_draw_check, which predicts and compares every random_value.
module tb_top;
    import lsr_pkg::*;

    // Longest legal quiet stretch is a rebuild plus idling; allow many times
    // that before declaring the block hung.
    localparam int QUIET_LIMIT    = 1000;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_REQUESTS = 204;

    localparam logic [VAL_W-1:0] SEED_MIN  = 31'd1;
    localparam logic [VAL_W-1:0] SEED_MAX  = 31'd2147483646;
    localparam logic [VAL_W-1:0] SEED_ZERO = 31'd0;
    localparam logic [VAL_W-1:0] SEED_ONES = 31'h7FFF_FFFF;

    logic             clk        = 1'b0;
    logic             rst_n      = 1'b0;
    logic             seed_valid = 1'b0;
    logic [VAL_W-1:0] seed       = '0;
    logic             in_valid   = 1'b0;
    logic             restart    = 1'b0;
    logic             out_ready  = 1'b0;
    wire              seed_ready;
    wire              in_ready;
    wire              out_valid;
    wire [VAL_W-1:0]  random_value;

    int mismatches;
    int requests_taken;
    int results_taken;
    int quiet_cycles = 0;

    // Idle pattern state: each side alternates between chunks with random
    // gaps and chunks that run flat out.
    int send_chunk = 0;
    bit send_idle  = 1'b0;
    int take_chunk = 0;
    bit take_idle  = 1'b0;

    always #4 clk = ~clk;

    lagged_subtractive_rng DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .seed_valid   (seed_valid),
        .seed_ready   (seed_ready),
        .seed         (seed),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .restart      (restart),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .random_value (random_value)
    );

    lsr_draw_check draw_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .seed_valid     (seed_valid),
        .seed_ready     (seed_ready),
        .seed           (seed),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .restart        (restart),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .random_value   (random_value),
        .mismatches     (mismatches),
        .requests_taken (requests_taken),
        .results_taken  (results_taken)
    );

    // Draw the wait before the next transfer; refresh the idle mode per chunk.
    function automatic int draw_wait(inout int chunk_left, inout bit idle_on);
        if (chunk_left == 0)
        begin
            chunk_left = $urandom_range(8, 40);
            idle_on    = ($urandom_range(0, 3) != 0);
        end
        chunk_left--;
        return idle_on ? int'($urandom_range(0, 6)) : 0;
    endfunction

    // Issue one request. Drop valid only when a gap is drawn, so valid never
    // falls and rises within the same time step; hold it until accepted.
    task automatic send_request(input logic rebuild);
        int gap;
        gap = draw_wait(send_chunk, send_idle);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        restart  <= rebuild;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Stop issuing and wait until every request has produced its result.
    // The counters are registered, so always advance at least once.
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (requests_taken != results_taken);
    endtask

    // Write the seed register; call only after drain().
    task automatic write_seed(input logic [VAL_W-1:0] value);
        seed_valid <= 1'b1;
        seed       <= value;
        @(posedge clk);
        while (!seed_ready)
            @(posedge clk);
        seed_valid <= 1'b0;
    endtask

    // Result side: after each accepted result, drop ready for a random number
    // of cycles, then raise it and hold it until the next result is taken.
    initial
    begin
        int stall;
        stall = 0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        out_ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                stall = draw_wait(take_chunk, take_idle);
                if (stall > 0)
                    out_ready <= 1'b0;
            end
            else if (!out_ready)
            begin
                stall--;
                if (stall <= 0)
                    out_ready <= 1'b1;
            end
        end
    end

    // Watchdog: count edges with no transfer on any channel.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (seed_valid && seed_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("lagged_subtractive_rng: mismatch");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        logic [VAL_W-1:0] phase_seed;
        int               pick;

        // Hold reset, release it once and let the block settle.
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Reset seed: the first request rebuilds even with restart clear.
        send_request(1'b0);
        repeat (3) send_request(1'b0);
        // Explicit restarts, back to back, then a plain draw.
        send_request(1'b1);
        send_request(1'b1);
        send_request(1'b0);

        // Largest legal seed: it must not touch the table until a restart.
        drain();
        write_seed(SEED_MAX);
        send_request(1'b0);
        send_request(1'b1);
        send_request(1'b0);

        // Out-of-range seeds fill the table with zeros.
        drain();
        write_seed(SEED_ZERO);
        send_request(1'b1);
        send_request(1'b0);
        send_request(1'b0);

        drain();
        write_seed(SEED_ONES);
        send_request(1'b1);
        send_request(1'b0);
        send_request(1'b0);

        // Smallest legal seed; the first draw still runs on the zero table.
        drain();
        write_seed(SEED_MIN);
        send_request(1'b0);
        send_request(1'b1);
        send_request(1'b0);

        // Random phases: a new seed each time, long runs of plain draws so the
        // tap index wraps, and rare restarts. Now and then pause the request
        // side until every result has come back.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            drain();
            pick = $urandom_range(0, 5);
            case (pick)
                0:       phase_seed = SEED_MIN;
                1:       phase_seed = SEED_MAX;
                default: phase_seed = VAL_W'($urandom());
            endcase
            write_seed(phase_seed);
            for (int n = 0; n < PHASE_REQUESTS; n++)
            begin
                if ($urandom_range(0, 99) == 0)
                    drain();
                if (n == 0)
                    send_request(1'($urandom_range(0, 1)));
                else
                    send_request($urandom_range(0, 63) == 0);
            end
        end

        // Let the last results come back, then allow a few cycles of slack.
        drain();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && requests_taken == results_taken)
            $display("lagged_subtractive_rng: match");
        else
            $display("lagged_subtractive_rng: mismatch");
        $finish;
    end

endmodule

// File: filelist.f
src/lsr_pkg.sv
src/lsr_ctrl.sv
src/lsr_datapath.sv
src/lagged_subtractive_rng.sv
src/lsr_checker.sv
verif/lsr_draw_check.sv
verif/tb_top.sv
